// ===== sv/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Branch codes, field widths and the lane count used by the conversion
// pipeline and its divider unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Width of every matrix element and quaternion component.
  localparam int unsigned ElemW = 16;
  // Width of an off-diagonal sum or difference of two elements.
  localparam int unsigned NumW = ElemW + 1;
  // Three components per item are produced by division.
  localparam int unsigned NumLanes = 3;
  // Quotient bits kept before saturation; anything larger saturates.
  localparam int unsigned QuoW = ElemW;

  typedef logic [1:0] sel_t;

  // Branch codes; the code is also the position of the main component.
  localparam sel_t BrTrace = 2'd0;
  localparam sel_t BrX     = 2'd1;
  localparam sel_t BrY     = 2'd2;
  localparam sel_t BrZ     = 2'd3;

  localparam logic signed [ElemW-1:0] SatMax = 16'sh7fff;
  localparam logic signed [ElemW-1:0] SatMin = -16'sh8000;

endpackage

// ===== sv/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt: pipelined integer square root
// Digit-by-digit root, one result bit per register stage, with a sideband
// that travels alongside each beat.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int unsigned VW  = 48,
  parameter int unsigned SBW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [VW-1:0]     v_i,
  input  logic [SBW-1:0]    sb_i,
  output logic              valid_o,
  output logic [VW/2-1:0]   root_o,
  output logic [SBW-1:0]    sb_o
);

  localparam int unsigned RtW = VW / 2;
  localparam int unsigned RmW = RtW + 2;

  logic [VW-1:0]  v_q     [RtW];
  logic [RmW-1:0] rem_q   [RtW];
  logic [RtW-1:0] res_q   [RtW];
  logic [SBW-1:0] sb_q    [RtW];
  logic           valid_q [RtW];

  for (genvar k = 0; k < RtW; k++) begin : g_stage
    logic [VW-1:0]  v_in;
    logic [RmW-1:0] rem_in;
    logic [RtW-1:0] res_in;
    logic [SBW-1:0] sb_in;
    logic           valid_in;
    logic [RmW-1:0] rem_sh;
    logic [RmW-1:0] trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in     = v_i;
      assign rem_in   = '0;
      assign res_in   = '0;
      assign sb_in    = sb_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign v_in     = v_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign res_in   = res_q[k-1];
      assign sb_in    = sb_q[k-1];
      assign valid_in = valid_q[k-1];
    end

    assign rem_sh = {rem_in[RmW-3:0], v_in[VW-1 -: 2]};
    assign trial  = {res_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]   <= v_in << 2;
        rem_q[k] <= ge ? (rem_sh - trial) : rem_sh;
        res_q[k] <= {res_in[RtW-2:0], ge};
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = valid_q[RtW-1];
  assign root_o  = res_q[RtW-1];
  assign sb_o    = sb_q[RtW-1];

endmodule

// ===== sv/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div: pipelined three-lane fractional divider
// Computes |num| * 2^FRAC_BITS / s for three numerators sharing one divisor,
// one quotient bit per stage, and flags quotients that do not fit.
// ----------------------------------------------------------------------------
module rmq_div
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned SW        = 25,
  parameter int unsigned SBW       = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [SW-1:0]                          s_i,
  input  logic [NumLanes-1:0][NumW-1:0]          num_i,
  input  logic [SBW-1:0]                         sb_i,
  output logic                                   valid_o,
  output logic [NumLanes-1:0][QuoW-1:0]          mag_o,
  output logic [NumLanes-1:0]                    neg_o,
  output logic [NumLanes-1:0]                    ovf_o,
  output logic [SBW-1:0]                         sb_o
);

  localparam int unsigned CW = SW + QuoW + 1;

  logic [NumLanes-1:0][CW-1:0]   rem_q   [QuoW+1];
  logic [NumLanes-1:0][QuoW-1:0] quo_q   [QuoW+1];
  logic [NumLanes-1:0]           neg_q   [QuoW+1];
  logic [NumLanes-1:0]           ovf_q   [QuoW+1];
  logic [SW-1:0]                 s_q     [QuoW+1];
  logic [SBW-1:0]                sb_q    [QuoW+1];
  logic                          valid_q [QuoW+1];

  // Entry stage: magnitude, scaled dividend and the overflow test.
  logic [NumLanes-1:0][CW-1:0] rem0_d;
  logic [NumLanes-1:0]         neg0_d;
  logic [NumLanes-1:0]         ovf0_d;

  always_comb begin
    logic [NumW-1:0] mag;
    for (int l = 0; l < NumLanes; l++) begin
      neg0_d[l] = num_i[l][NumW-1];
      mag       = neg0_d[l] ? (~num_i[l] + 1'b1) : num_i[l];
      rem0_d[l] = CW'(mag) << FRAC_BITS;
      ovf0_d[l] = (rem0_d[l] >= (CW'(s_i) << QuoW));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0_d;
      quo_q[0] <= '0;
      neg_q[0] <= neg0_d;
      ovf_q[0] <= ovf0_d;
      s_q[0]   <= s_i;
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_stage
    localparam int unsigned Bit = QuoW - k;
    logic [NumLanes-1:0][CW-1:0]   rem_d;
    logic [NumLanes-1:0][QuoW-1:0] quo_d;
    logic [CW-1:0]                 trial;

    assign trial = CW'(s_q[k-1]) << Bit;

    always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
        rem_d[l] = rem_q[k-1][l];
        quo_d[l] = quo_q[k-1][l];
        if (rem_q[k-1][l] >= trial) begin
          rem_d[l]      = rem_q[k-1][l] - trial;
          quo_d[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        s_q[k]   <= s_q[k-1];
        sb_q[k]  <= sb_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[QuoW];
  assign mag_o   = quo_q[QuoW];
  assign neg_o   = neg_q[QuoW];
  assign ovf_o   = ovf_q[QuoW];
  assign sb_o    = sb_q[QuoW];

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Fixed-point conversion with the four-way branch, a pipelined square root
// and a pipelined three-lane divider.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid_i / in_ready_o) carries one matrix per
// beat as nine signed elements m00_i..m22_i. The output channel
// (out_valid_o / out_ready_i) carries one quaternion per beat as qw_o..qz_o
// and degenerate_o, which is set, with all four components zero, when the
// branch radicand is not positive. Every component is saturated.
// Throughput is one matrix per clock while the receiver does not stall. The
// pipeline holds a register for branch selection and radicand, one
// stage per root bit (FRAC_BITS + 10 stages) in the square root, one entry
// stage and sixteen quotient stages in the divider, and the output register.
// The depth is set by the bit-per-stage root and quotient units.
// Reset clears every valid bit, so the pipeline comes up empty; payload
// registers are not reset. When the receiver stalls, the whole pipeline
// freezes in place and in_ready_o falls, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ElemW-1:0] m00_i,
  input  logic signed [ElemW-1:0] m01_i,
  input  logic signed [ElemW-1:0] m02_i,
  input  logic signed [ElemW-1:0] m10_i,
  input  logic signed [ElemW-1:0] m11_i,
  input  logic signed [ElemW-1:0] m12_i,
  input  logic signed [ElemW-1:0] m20_i,
  input  logic signed [ElemW-1:0] m21_i,
  input  logic signed [ElemW-1:0] m22_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ElemW-1:0] qw_o,
  output logic signed [ElemW-1:0] qx_o,
  output logic signed [ElemW-1:0] qy_o,
  output logic signed [ElemW-1:0] qz_o,
  output logic                    degenerate_o
);

  // Radicand width: one plus three elements fits comfortably.
  localparam int unsigned RadW  = FRAC_BITS + 19;
  // Root width; the root input is the radicand scaled by 2^FRAC_BITS.
  localparam int unsigned RootW = (RadW + FRAC_BITS) / 2 + 1;
  localparam int unsigned SqVW  = 2 * RootW;
  localparam int unsigned SW    = RootW + 1;
  // Sideband through the root: branch, degenerate flag, three numerators.
  localparam int unsigned Sb1W  = 2 + 1 + NumLanes * NumW;
  // Sideband through the divider: branch, degenerate flag, main component.
  localparam int unsigned Sb2W  = 2 + 1 + ElemW;

  localparam logic signed [RadW-1:0] One = RadW'(1) << FRAC_BITS;

  // One global advance enable: the pipeline moves whenever the output
  // register is empty or being drained.
  logic en;
  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Stage A: branch selection, radicand, and the numerators for the three
  // divided components, ordered by output position with the main one left out.
  // --------------------------------------------------------------------------
  logic signed [NumW:0]    trace;
  logic signed [RadW-1:0]  e00, e11, e22;
  logic signed [NumW-1:0]  n_xw, n_yw, n_zw, n_xy, n_xz, n_yz;
  sel_t                    sel_d;
  logic signed [RadW-1:0]  rad_d;
  logic [NumLanes-1:0][NumW-1:0] num_d;

  assign e00   = RadW'(m00_i);
  assign e11   = RadW'(m11_i);
  assign e22   = RadW'(m22_i);
  assign trace = (NumW+1)'(m00_i) + (NumW+1)'(m11_i) + (NumW+1)'(m22_i);

  assign n_xw = NumW'(m21_i) - NumW'(m12_i);
  assign n_yw = NumW'(m02_i) - NumW'(m20_i);
  assign n_zw = NumW'(m10_i) - NumW'(m01_i);
  assign n_xy = NumW'(m01_i) + NumW'(m10_i);
  assign n_xz = NumW'(m02_i) + NumW'(m20_i);
  assign n_yz = NumW'(m12_i) + NumW'(m21_i);

  always_comb begin
    if (trace > 0) begin
      sel_d = BrTrace;
      rad_d = One + e00 + e11 + e22;
      num_d = {n_zw, n_yw, n_xw};
    end else if ((m00_i > m11_i) && (m00_i > m22_i)) begin
      sel_d = BrX;
      rad_d = One + e00 - e11 - e22;
      num_d = {n_xz, n_xy, n_xw};
    end else if (m11_i > m22_i) begin
      sel_d = BrY;
      rad_d = One + e11 - e00 - e22;
      num_d = {n_yz, n_xy, n_yw};
    end else begin
      sel_d = BrZ;
      rad_d = One + e22 - e00 - e11;
      num_d = {n_yz, n_xz, n_zw};
    end
  end

  logic                          a_valid_q;
  sel_t                          a_sel_q;
  logic signed [RadW-1:0]        a_rad_q;
  logic [NumLanes-1:0][NumW-1:0] a_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sel_q <= sel_d;
      a_rad_q <= rad_d;
      a_num_q <= num_d;
    end
  end

  // A non-positive radicand feeds zero to the root; its result is discarded.
  logic          a_deg;
  logic [SqVW-1:0] a_v;
  assign a_deg = (a_rad_q <= 0);
  assign a_v   = a_deg ? '0 : (SqVW'(a_rad_q[RadW-2:0]) << FRAC_BITS);

  // --------------------------------------------------------------------------
  // Square root.
  // --------------------------------------------------------------------------
  logic             r_valid;
  logic [RootW-1:0] r_root;
  logic [Sb1W-1:0]  r_sb;

  rmq_sqrt #(
    .VW  (SqVW),
    .SBW (Sb1W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .v_i     (a_v),
    .sb_i    ({a_sel_q, a_deg, a_num_q}),
    .valid_o (r_valid),
    .root_o  (r_root),
    .sb_o    (r_sb)
  );

  // S = 2r; the main component is S/4 = r/2, saturated to the positive range.
  sel_t                          r_sel;
  logic                          r_deg;
  logic [NumLanes-1:0][NumW-1:0] r_num;
  logic [RootW-2:0]              r_half;
  logic signed [ElemW-1:0]       r_main;

  assign {r_sel, r_deg, r_num} = r_sb;
  assign r_half = r_root[RootW-1:1];
  assign r_main = (r_half > (RootW-1)'(SatMax)) ? SatMax : ElemW'(r_half);

  // --------------------------------------------------------------------------
  // Divider.
  // --------------------------------------------------------------------------
  logic                          d_valid;
  logic [NumLanes-1:0][QuoW-1:0] d_mag;
  logic [NumLanes-1:0]           d_neg;
  logic [NumLanes-1:0]           d_ovf;
  logic [Sb2W-1:0]               d_sb;

  rmq_div #(
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW),
    .SBW       (Sb2W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_valid),
    .s_i     ({r_root, 1'b0}),
    .num_i   (r_num),
    .sb_i    ({r_sel, r_deg, r_main}),
    .valid_o (d_valid),
    .mag_o   (d_mag),
    .neg_o   (d_neg),
    .ovf_o   (d_ovf),
    .sb_o    (d_sb)
  );

  sel_t                    d_sel;
  logic                    d_deg;
  logic signed [ElemW-1:0] d_main;
  assign {d_sel, d_deg, d_main} = d_sb;

  // Signed saturation of a quotient magnitude.
  function automatic logic signed [ElemW-1:0] sat_quo(
    input logic [QuoW-1:0] mag,
    input logic            neg,
    input logic            ovf
  );
    logic signed [ElemW-1:0] res;
    if (neg) begin
      res = (ovf || (mag > QuoW'(SatMax) + 1'b1)) ? SatMin : -$signed(mag);
    end else begin
      res = (ovf || (mag > QuoW'(SatMax))) ? SatMax : $signed(mag);
    end
    return res;
  endfunction

  logic signed [NumLanes-1:0][ElemW-1:0] lane_val;
  logic signed [3:0][ElemW-1:0]          q_d;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      lane_val[l] = sat_quo(d_mag[l], d_neg[l], d_ovf[l]);
    end
    // Lanes fill the non-main positions in ascending order.
    for (int p = 0; p < 4; p++) begin
      if (d_deg) begin
        q_d[p] = '0;
      end else if (sel_t'(p) == d_sel) begin
        q_d[p] = d_main;
      end else if (sel_t'(p) < d_sel) begin
        q_d[p] = lane_val[p];
      end else begin
        q_d[p] = lane_val[p-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic                          out_valid_q;
  logic signed [3:0][ElemW-1:0]  q_q;
  logic                          deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q   <= q_d;
      deg_q <= d_deg;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign qw_o         = q_q[0];
  assign qx_o         = q_q[1];
  assign qy_o         = q_q[2];
  assign qz_o         = q_q[3];
  assign degenerate_o = deg_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |->
      (qw_o == '0 && qx_o == '0 && qy_o == '0 && qz_o == '0))
    else $error("degenerate result with nonzero components");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the pipeline advance");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(q_q)))
    else $error("stalled result changed or vanished");

endmodule

// ===== bench/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker: prediction and comparison for the quaternion converter
// Watches both channels, computes the quaternion of each accepted matrix
// and compares every accepted result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module rmq_checker
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [ElemW-1:0] m00_i,
  input  logic signed [ElemW-1:0] m01_i,
  input  logic signed [ElemW-1:0] m02_i,
  input  logic signed [ElemW-1:0] m10_i,
  input  logic signed [ElemW-1:0] m11_i,
  input  logic signed [ElemW-1:0] m12_i,
  input  logic signed [ElemW-1:0] m20_i,
  input  logic signed [ElemW-1:0] m21_i,
  input  logic signed [ElemW-1:0] m22_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [ElemW-1:0] qw_i,
  input  logic signed [ElemW-1:0] qx_i,
  input  logic signed [ElemW-1:0] qy_i,
  input  logic signed [ElemW-1:0] qz_i,
  input  logic                    degenerate_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      degen_seen_o,
  output int                      branch_seen_o [4]
);

  typedef struct packed {
    logic signed [ElemW-1:0] w;
    logic signed [ElemW-1:0] x;
    logic signed [ElemW-1:0] y;
    logic signed [ElemW-1:0] z;
    logic                    degen;
  } quat_t;

  quat_t quat_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [ElemW-1:0] clamp16(longint v);
    if (v > 32767) return SatMax;
    if (v < -32768) return SatMin;
    return v[ElemW-1:0];
  endfunction

  // Scaled quotient, truncated toward zero.
  function automatic longint frac_div(longint num, longint unsigned s);
    longint unsigned mag;
    longint unsigned quo;
    mag = (num < 0) ? longint'(-num) : num;
    quo = (mag << FRAC_BITS) / s;
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic quat_t convert(longint a00, longint a01, longint a02,
                                    longint a10, longint a11, longint a12,
                                    longint a20, longint a21, longint a22,
                                    output sel_t br);
    longint one;
    longint rad;
    longint unsigned s;
    longint comp [4];
    quat_t q;
    one = longint'(1) << FRAC_BITS;
    if (a00 + a11 + a22 > 0) begin
      br = BrTrace;
      rad = one + a00 + a11 + a22;
    end else if (a00 > a11 && a00 > a22) begin
      br = BrX;
      rad = one + a00 - a11 - a22;
    end else if (a11 > a22) begin
      br = BrY;
      rad = one + a11 - a00 - a22;
    end else begin
      br = BrZ;
      rad = one + a22 - a00 - a11;
    end
    q = '0;
    if (rad <= 0) begin
      q.degen = 1'b1;
      return q;
    end
    s = 2 * int_sqrt(longint'(rad) << FRAC_BITS);
    comp[br] = longint'(s >> 2);
    case (br)
      BrTrace: begin
        comp[1] = frac_div(a21 - a12, s);
        comp[2] = frac_div(a02 - a20, s);
        comp[3] = frac_div(a10 - a01, s);
      end
      BrX: begin
        comp[0] = frac_div(a21 - a12, s);
        comp[2] = frac_div(a01 + a10, s);
        comp[3] = frac_div(a02 + a20, s);
      end
      BrY: begin
        comp[0] = frac_div(a02 - a20, s);
        comp[1] = frac_div(a01 + a10, s);
        comp[3] = frac_div(a12 + a21, s);
      end
      default: begin
        comp[0] = frac_div(a10 - a01, s);
        comp[1] = frac_div(a02 + a20, s);
        comp[2] = frac_div(a12 + a21, s);
      end
    endcase
    q.w = clamp16(comp[0]);
    q.x = clamp16(comp[1]);
    q.y = clamp16(comp[2]);
    q.z = clamp16(comp[3]);
    return q;
  endfunction

  initial begin
    errors_o = 0;
    degen_seen_o = 0;
    for (int i = 0; i < 4; i++) branch_seen_o[i] = 0;
  end

  assign pending_o = quat_q.size();

  always @(posedge clk_i) begin
    quat_t exp_q;
    quat_t got;
    sel_t br;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        exp_q = convert(m00_i, m01_i, m02_i, m10_i, m11_i, m12_i,
                        m20_i, m21_i, m22_i, br);
        branch_seen_o[br]++;
        if (exp_q.degen) degen_seen_o++;
        quat_q.push_back(exp_q);
      end
      if (out_valid_i && out_ready_i) begin
        got = '{qw_i, qx_i, qy_i, qz_i, degenerate_i};
        if (quat_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %p", $time, got);
          errors_o++;
        end else begin
          exp_q = quat_q.pop_front();
          if (got !== exp_q) begin
            $display("%0t: mismatch w/x/y/z/degen expected %0d %0d %0d %0d %0b",
                     $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.degen);
            $display("%0t:                          actual %0d %0d %0d %0d %0b",
                     $time, got.w, got.x, got.y, got.z, got.degen);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion: stimulus and verdict for the converter
// Drives directed and random matrices through the valid/ready input with
// random gaps and output stalls; the checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int unsigned FracBits = 14;
  // Pipeline depth of the converter.
  localparam int Latency = FracBits + 29;
  localparam int HoldLen = 4 * Latency;
  localparam int WatchdogLimit = 5000;
  // Items spread over the three random phases; the hold-off phase and the
  // directed matrices come on top.
  localparam int RandomItems = 960;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [ElemW-1:0] mat [9];
  logic out_valid;
  logic out_ready;
  logic signed [ElemW-1:0] qw, qx, qy, qz;
  logic degenerate;

  int errors;
  int pending;
  int degen_seen;
  int branch_seen [4];

  // Idle percentages of each side; changed between phases.
  int send_idle_pct;
  int recv_idle_pct;
  // A long hold-off of the receiver, requested by the stimulus and counted
  // in the receiver's own process.
  bit hold_go;
  int hold_cycles;
  int stall_cycles;
  int accepted;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  rotation_matrix_to_quaternion #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .m00_i        (mat[0]),
    .m01_i        (mat[1]),
    .m02_i        (mat[2]),
    .m10_i        (mat[3]),
    .m11_i        (mat[4]),
    .m12_i        (mat[5]),
    .m20_i        (mat[6]),
    .m21_i        (mat[7]),
    .m22_i        (mat[8]),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .qw_o         (qw),
    .qx_o         (qx),
    .qy_o         (qy),
    .qz_o         (qz),
    .degenerate_o (degenerate)
  );

  rmq_checker #(
    .FRAC_BITS(FracBits)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .m00_i        (mat[0]),
    .m01_i        (mat[1]),
    .m02_i        (mat[2]),
    .m10_i        (mat[3]),
    .m11_i        (mat[4]),
    .m12_i        (mat[5]),
    .m20_i        (mat[6]),
    .m21_i        (mat[7]),
    .m22_i        (mat[8]),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .qw_i         (qw),
    .qx_i         (qx),
    .qy_i         (qy),
    .qz_i         (qz),
    .degenerate_i (degenerate),
    .errors_o     (errors),
    .pending_o    (pending),
    .degen_seen_o (degen_seen),
    .branch_seen_o(branch_seen)
  );

  // Receiver: random stalls, or a solid hold-off once hold_go is raised,
  // until hold_cycles reaches HoldLen.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_go && (hold_cycles < HoldLen)) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one matrix and holds it until the block takes it. Random gaps are
  // inserted before the beat according to the current sender idle rate.
  task automatic send_matrix(input logic signed [ElemW-1:0] m [9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) mat[i] <= m[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A rotation-shaped matrix about one axis, scaled to Q1.14, with optional
  // noise, so the diagonal spreads over all four branches.
  function automatic void make_rotation(output logic signed [ElemW-1:0] m [9]);
    int c, s;
    int axis;
    c = $urandom_range(32768) - 16384;
    s = $urandom_range(32768) - 16384;
    axis = $urandom_range(2);
    for (int i = 0; i < 9; i++) m[i] = '0;
    case (axis)
      0: begin
        m[0] = 16384; m[4] = ElemW'(c); m[5] = ElemW'(-s); m[7] = ElemW'(s);
        m[8] = ElemW'(c);
      end
      1: begin
        m[0] = ElemW'(c); m[2] = ElemW'(s); m[4] = 16384; m[6] = ElemW'(-s);
        m[8] = ElemW'(c);
      end
      default: begin
        m[0] = ElemW'(c); m[1] = ElemW'(-s); m[3] = ElemW'(s); m[4] = ElemW'(c);
        m[8] = 16384;
      end
    endcase
    if ($urandom_range(3) == 0)
      for (int i = 0; i < 9; i++)
        m[i] = ElemW'(m[i] + $signed($urandom_range(64)) - 32);
  endfunction

  function automatic void make_noise(output logic signed [ElemW-1:0] m [9]);
    for (int i = 0; i < 9; i++) m[i] = ElemW'($urandom());
  endfunction

  task automatic random_phase(input int count);
    logic signed [ElemW-1:0] m [9];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 7) make_rotation(m);
      else make_noise(m);
      send_matrix(m);
    end
  endtask

  initial begin
    logic signed [ElemW-1:0] m [9];
    rst_n = 1'b0;
    in_valid = 1'b0;
    hold_go = 1'b0;
    for (int i = 0; i < 9; i++) mat[i] = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    accepted = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: identity, the three half-turns (one per branch besides
    // the trace), a tie on a zero diagonal, huge off-diagonals and the
    // field extremes.
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};        send_matrix(m);
    m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};      send_matrix(m);
    m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};      send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};      send_matrix(m);
    // All-zero diagonal: trace not positive, tie falls to the z branch.
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                    send_matrix(m);
    // Large diagonal in the trace branch; the radicand stays positive.
    m = '{32767, 5, 5, 5, 32767, 5, 5, 5, -32768};       send_matrix(m);
    // Large radicand in the z branch.
    m = '{-16000, 1, 2, 3, -32768, 4, 5, 6, 32767};     send_matrix(m);
    // Negative m00 alone: trace not positive, tie falls to the z branch.
    m = '{-16384, 0, 0, 0, 0, 0, 0, 0, 0};               send_matrix(m);
    // Huge off-diagonals in the z and y branches.
    m = '{-32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768, 16384};
    send_matrix(m);
    m = '{-32768, -32768, -32768, -32768, 16384, -32768, -32768, -32768, -32768};
    send_matrix(m);
    m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_matrix(m);
    m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_matrix(m);
    m = '{1, -1, 1, -1, 0, 1, -1, 1, -1};               send_matrix(m);
    m = '{-1, 32767, -32768, 32767, -1, -32768, 32767, -32768, -2};
    send_matrix(m);
    m = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
          16'sh5555, 16'shaaaa, 16'sh5555};
    send_matrix(m);
    m = '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
          16'shaaaa, 16'sh5555, 16'shaaaa};
    send_matrix(m);
    drain();

    // Sender idles often, receiver idles even more.
    send_idle_pct = 26;
    recv_idle_pct = 76;
    random_phase(RandomItems / 3);

    // Long receiver hold-off while the sender keeps offering beats, so the
    // pipeline fills and in_ready falls; then a full pause until drained.
    send_idle_pct = 0;
    hold_go = 1'b1;
    random_phase(3 * Latency);
    drain();

    send_idle_pct = 76;
    recv_idle_pct = 26;
    random_phase(RandomItems / 3);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(RandomItems / 3);
    drain();
    repeat (Latency + 5) @(posedge clk);

    $display("Converted %0d matrices: trace/x/y/z branches %0d/%0d/%0d/%0d, %0d degenerate.",
             accepted, branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3],
             degen_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rmq_pkg.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
bench/rmq_checker.sv
bench/tb_rotation_matrix_to_quaternion.sv
